### design/hkvs_pkg.sv
// Shared constants for the bucketed hash key-value store.
// Request and status codes, default geometry. No dependencies.
`default_nettype none

package hkvs_pkg;

  localparam int unsigned DEF_NUM_BUCKETS = 256;
  localparam int unsigned DEF_WAYS        = 4;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 32;

  localparam logic [1:0] REQ_UPSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_ABSENT = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

endpackage

`default_nettype wire

### design/hkvs_if.sv
// Request and response channel interfaces for the key-value store.
// Valid/ready handshake with payload; depends on hkvs_pkg.
`default_nettype none

interface hkvs_req_if
  import hkvs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [KEY_W-1:0]   req_key;
  logic [VALUE_W-1:0] req_value;

  modport source (output valid, output req_type, output req_key, output req_value,
                  input ready);
  modport sink   (input valid, input req_type, input req_key, input req_value,
                  output ready);
endinterface

interface hkvs_rsp_if
  import hkvs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               found;
  logic [VALUE_W-1:0] read_value;
  logic [1:0]         status;

  modport source (output valid, output found, output read_value, output status,
                  input ready);
  modport sink   (input valid, input found, input read_value, input status,
                  output ready);
endinterface

`default_nettype wire

### design/hkvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hkvs_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/bucketed_hash_key_value_store_top.sv
// Bucketed hash key-value store: upsert, delete and search of 64-bit keys.
// Depends on hkvs_pkg, hkvs_req_if / hkvs_rsp_if and hkvs_ram.
//
// Usage:
//   in_req carries one request transaction (req_type, req_key, req_value);
//   out_rsp returns exactly one response transaction (found, read_value,
//   status) per request, in request order.
//   One request is in flight at a time; in_req.ready is high only while idle.
//   The bucket is the 32-bit XOR-fold of the key modulo NUM_BUCKETS: a mask
//   when NUM_BUCKETS is a power of two, otherwise a reciprocal multiply, a
//   multiply back and a subtract in S_MOD steps on one shared multiplier.
//   The ways of the bucket are then compared one per cycle on a single
//   64-bit comparator, fed by the registered read port of the key RAM.
//   Each request passes through S_ROW, S_SCAN and S_COMMIT (after S_MOD
//   when NUM_BUCKETS is not a power of two); a new request is taken the
//   cycle after the response is loaded, so requests never overlap.
//   After reset the valid-bit RAM is swept clear, one bucket per cycle, over
//   all NUM_BUCKETS buckets, with in_req.ready low.
//   The response sits in an output register; a stalled receiver holds it,
//   and the next request completes only once that register is taken.
`default_nettype none

module bucketed_hash_key_value_store_top
  import hkvs_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = DEF_NUM_BUCKETS,
  parameter int unsigned WAYS        = DEF_WAYS
) (
  input wire logic clk,
  input wire logic rst_n,
  hkvs_req_if.sink   in_req,
  hkvs_rsp_if.source out_rsp
);

  localparam int unsigned BW      = $clog2(NUM_BUCKETS);
  localparam int unsigned WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CW      = $clog2(WAYS + 1);
  localparam int unsigned ENTRIES = NUM_BUCKETS * WAYS;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam bit          IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
  localparam int unsigned RS      = 32 + BW;

  localparam logic [32:0]   NB_W      = 33'(NUM_BUCKETS);
  localparam logic [32:0]   RECIP     =
    33'(((64'd1 << RS) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));
  localparam logic [BW-1:0] LAST_BKT  = BW'(NUM_BUCKETS - 1);
  localparam logic [CW-1:0] LAST_WAY  = CW'(WAYS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_ROW,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t             state_r;
  logic [BW-1:0]      clr_r;
  logic [1:0]         type_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic [31:0]        fold_r;
  logic [64:0]        prod_r;
  logic [1:0]         step_r;
  logic [BW-1:0]      bucket_r;
  logic [CW-1:0]      way_r;
  logic               hit_r;
  logic [WW-1:0]      hit_way_r;
  logic               free_r;
  logic [WW-1:0]      free_way_r;
  logic [VALUE_W-1:0] hit_val_r;

  logic               out_valid_r;
  logic               found_r;
  logic [VALUE_W-1:0] read_value_r;
  logic [1:0]         status_r;

  logic [31:0]        fold;
  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic [64:0]        mul_p;
  logic [WW-1:0]      way_idx;
  logic               way_last;
  logic [AW-1:0]      base_addr;
  logic               accept;
  logic               commit;

  logic               vram_we;
  logic [BW-1:0]      vram_waddr;
  logic [WAYS-1:0]    vram_wdata;
  logic               vram_re;
  logic [WAYS-1:0]    row_rdata;

  logic               kram_we;
  logic               dram_we;
  logic [AW-1:0]      ent_waddr;
  logic               ent_re;
  logic [AW-1:0]      ent_raddr;
  logic [KEY_W-1:0]   key_rdata;
  logic [VALUE_W-1:0] val_rdata;

  logic               cmp_hit;
  logic               cmp_free;

  assign accept   = in_req.valid && in_req.ready;
  assign fold     = in_req.req_key[31:0] ^ in_req.req_key[63:32];
  assign mul_a    = (step_r == 2'd0) ? RECIP : NB_W;
  assign mul_b    = (step_r == 2'd0) ? fold_r : 32'(prod_r >> RS);
  assign mul_p    = 65'(mul_a) * 65'(mul_b);
  assign way_idx  = way_r[WW-1:0];
  assign way_last = (way_r == LAST_WAY);
  assign base_addr = AW'(bucket_r) * AW'(WAYS);
  assign commit   = (state_r == S_COMMIT) && (!out_valid_r || out_rsp.ready);

  assign cmp_hit  = row_rdata[way_idx] && (key_rdata == key_r) && !hit_r;
  assign cmp_free = !row_rdata[way_idx] && !free_r;

  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    vram_we    = 1'b0;
    vram_waddr = bucket_r;
    vram_wdata = row_rdata;
    kram_we    = 1'b0;
    dram_we    = 1'b0;
    ent_waddr  = base_addr + AW'(free_way_r);
    if (state_r == S_CLEAR) begin
      vram_we    = 1'b1;
      vram_waddr = clr_r;
      vram_wdata = '0;
    end else if (commit) begin
      case (type_r)
        REQ_UPSERT: begin
          if (hit_r) begin
            dram_we   = 1'b1;
            ent_waddr = base_addr + AW'(hit_way_r);
          end else if (free_r) begin
            vram_we    = 1'b1;
            vram_wdata = row_rdata | (WAYS'(1) << free_way_r);
            kram_we    = 1'b1;
            dram_we    = 1'b1;
          end
        end
        REQ_DELETE: begin
          if (hit_r) begin
            vram_we    = 1'b1;
            vram_wdata = row_rdata & ~(WAYS'(1) << hit_way_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign vram_re   = (state_r == S_ROW);
  assign ent_re    = (state_r == S_ROW) || ((state_r == S_SCAN) && !way_last);
  assign ent_raddr = (state_r == S_ROW) ? base_addr : (base_addr + AW'(way_r) + AW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + BW'(1);
          if (clr_r == LAST_BKT) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            type_r   <= in_req.req_type;
            key_r    <= in_req.req_key;
            value_r  <= in_req.req_value;
            fold_r   <= fold;
            step_r   <= '0;
            bucket_r <= fold[BW-1:0];
            state_r  <= IS_POW2 ? S_ROW : S_MOD;
          end
        end
        S_MOD: begin
          prod_r <= mul_p;
          step_r <= step_r + 2'd1;
          if (step_r == 2'd2) begin
            bucket_r <= fold_r[BW-1:0] - prod_r[BW-1:0];
            state_r  <= S_ROW;
          end
        end
        S_ROW: begin
          way_r   <= '0;
          hit_r   <= 1'b0;
          free_r  <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (cmp_hit) begin
            hit_r     <= 1'b1;
            hit_way_r <= way_idx;
            hit_val_r <= val_rdata;
          end
          if (cmp_free) begin
            free_r     <= 1'b1;
            free_way_r <= way_idx;
          end
          way_r <= way_r + CW'(1);
          if (way_last) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            out_valid_r  <= 1'b1;
            found_r      <= hit_r;
            read_value_r <= '0;
            state_r      <= S_IDLE;
            case (type_r)
              REQ_UPSERT: begin
                status_r <= (hit_r || free_r) ? STAT_DONE : STAT_FULL;
              end
              REQ_DELETE: begin
                status_r <= hit_r ? STAT_DONE : STAT_ABSENT;
              end
              default: begin
                status_r     <= hit_r ? STAT_DONE : STAT_ABSENT;
                read_value_r <= hit_r ? hit_val_r : '0;
              end
            endcase
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.found      = found_r;
  assign out_rsp.read_value = read_value_r;
  assign out_rsp.status     = status_r;

  hkvs_ram #(
    .WIDTH  (WAYS),
    .DEPTH  (NUM_BUCKETS),
    .ADDR_W (BW)
  ) u_valid_ram (
    .clk     (clk),
    .wr_en   (vram_we),
    .wr_addr (vram_waddr),
    .wr_data (vram_wdata),
    .rd_en   (vram_re),
    .rd_addr (bucket_r),
    .rd_data (row_rdata)
  );

  hkvs_ram #(
    .WIDTH  (KEY_W),
    .DEPTH  (ENTRIES),
    .ADDR_W (AW)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (kram_we),
    .wr_addr (ent_waddr),
    .wr_data (key_r),
    .rd_en   (ent_re),
    .rd_addr (ent_raddr),
    .rd_data (key_rdata)
  );

  hkvs_ram #(
    .WIDTH  (VALUE_W),
    .DEPTH  (ENTRIES),
    .ADDR_W (AW)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (dram_we),
    .wr_addr (ent_waddr),
    .wr_data (value_r),
    .rd_en   (ent_re),
    .rd_addr (ent_raddr),
    .rd_data (val_rdata)
  );

endmodule

`default_nettype wire
